// ----- rtl/dep_pkg.sv -----
// Package with the shared types and constants of the double-ended priority queue.
`default_nettype none

package dep_pkg;

    localparam int KEY_W            = 32;
    localparam int DEFAULT_CAPACITY = 64;
    localparam int DEFAULT_COUNT_W  = 7;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DEL_MAX = 2'd1,
        REQ_DEL_MIN = 2'd2
    } t_req_type;

    typedef struct packed {
        logic                    ins;
        logic                    shl;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- rtl/dep_if.sv -----
// Request and response channel interfaces of the double-ended priority queue.
`default_nettype none

interface dep_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      req_type;
    logic signed [dep_pkg::KEY_W-1:0] key_value;

    modport source (output valid, output req_type, output key_value, input ready);
    modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface dep_rsp_if #(
    parameter int COUNT_W = dep_pkg::DEFAULT_COUNT_W
);
    logic                            valid;
    logic                            ready;
    logic signed [dep_pkg::KEY_W-1:0] max_key;
    logic signed [dep_pkg::KEY_W-1:0] min_key;
    logic [COUNT_W-1:0]              entry_count;
    logic                            is_empty;
    logic                            insert_dropped;

    modport source (output valid, output max_key, output min_key, output entry_count,
                    output is_empty, output insert_dropped, input ready);
    modport sink   (input valid, input max_key, input min_key, input entry_count,
                    input is_empty, input insert_dropped, output ready);
endinterface

`default_nettype wire

// ----- rtl/dep_cell.sv -----
// One cell of a sorted key chain, holding one key and trading keys with its neighbors.
`default_nettype none

module dep_cell #(
    parameter int IDX     = 0,
    parameter bit DESCEND = 1'b0,
    parameter int COUNT_W = dep_pkg::DEFAULT_COUNT_W
) (
    input  wire logic                             i_clk,
    input  wire dep_pkg::t_cell_ctrl              i_ctrl,
    input  wire logic [COUNT_W-1:0]               i_count,
    input  wire logic signed [dep_pkg::KEY_W-1:0] i_left_key,
    input  wire logic                             i_left_move,
    input  wire logic signed [dep_pkg::KEY_W-1:0] i_right_key,
    output logic signed [dep_pkg::KEY_W-1:0]      o_key,
    output logic signed [dep_pkg::KEY_W-1:0]      o_next_key,
    output logic                                  o_move
);

    logic signed [dep_pkg::KEY_W-1:0] r_key;
    logic                             w_in_range;
    logic                             w_after;

    assign w_in_range = COUNT_W'(IDX) < i_count;
    assign w_after    = DESCEND ? (i_ctrl.key > r_key) : (r_key > i_ctrl.key);

    // A used cell moves one place up when the new key belongs before it (not on a tie); unused cells always move.
    assign o_move = w_in_range ? w_after : 1'b1;

    always_comb begin
        priority if (i_ctrl.ins) begin
            if (o_move) begin
                o_next_key = i_left_move ? i_left_key : i_ctrl.key;
            end else begin
                o_next_key = r_key;
            end
        end else if (i_ctrl.shl) begin
            o_next_key = i_right_key;
        end else begin
            o_next_key = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= o_next_key;
    end

    assign o_key = r_key;

endmodule

`default_nettype wire

// ----- rtl/double_ended_priority_queue.sv -----
// Top level of the double-ended priority queue built from two sorted cell chains.
//
// The request channel i_req carries a request type (insert, delete maximum,
// delete minimum) and a signed key. Every accepted transaction produces one
// transaction on the response channel o_rsp with the maximum and minimum key,
// the entry count, an empty flag and a flag for an insert that found the
// queue full. Max and min read as zero while the queue is empty.
// The keys are held twice, once in an ascending and once in a descending
// chain of cells; every cell compares its key with the request in the same
// cycle and takes a key from a neighbor, so both chains stay sorted and the
// minimum and maximum always sit in the first cell of each chain.
// The response appears in the cycle after acceptance; one transaction is accepted
// per cycle unless the receiver stalls, set by the single compare-and-shift step of the cells.
// The response sits in an output register; a new request is accepted while
// that register is empty or being read in the same cycle, so a stalled
// receiver holds the request channel off without losing anything.
// Reset empties the queue and the output register.
`default_nettype none

module double_ended_priority_queue #(
    parameter int CAPACITY = dep_pkg::DEFAULT_CAPACITY
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dep_req_if.sink   i_req,
    dep_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic                             r_out_valid;
    logic signed [dep_pkg::KEY_W-1:0] r_max;
    logic signed [dep_pkg::KEY_W-1:0] r_min;
    logic [CW-1:0]                    r_out_count;
    logic                             r_empty;
    logic                             r_dropped;
    logic                             w_accept;
    logic                             w_full;
    logic                             w_dropped;
    dep_pkg::t_cell_ctrl              w_ctrl [2];

    logic signed [dep_pkg::KEY_W-1:0] w_key  [2][CAPACITY];
    logic signed [dep_pkg::KEY_W-1:0] w_next [2][CAPACITY];
    logic                             w_move [2][CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = r_count == CW'(CAPACITY);

    always_comb begin
        n_count   = r_count;
        w_dropped = 1'b0;
        for (int c = 0; c < 2; c++) begin
            w_ctrl[c].ins = 1'b0;
            w_ctrl[c].shl = 1'b0;
            w_ctrl[c].key = i_req.key_value;
        end
        if (w_accept) begin
            unique case (i_req.req_type)
                dep_pkg::REQ_INSERT: begin
                    if (w_full) begin
                        w_dropped = 1'b1;
                    end else begin
                        w_ctrl[0].ins = 1'b1;
                        w_ctrl[1].ins = 1'b1;
                        n_count       = r_count + CW'(1);
                    end
                end
                dep_pkg::REQ_DEL_MAX: begin
                    if (r_count != '0) begin
                        w_ctrl[1].shl = 1'b1;
                        n_count       = r_count - CW'(1);
                    end
                end
                dep_pkg::REQ_DEL_MIN: begin
                    if (r_count != '0) begin
                        w_ctrl[0].shl = 1'b1;
                        n_count       = r_count - CW'(1);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    for (genvar c = 0; c < 2; c++) begin : g_chain
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic signed [dep_pkg::KEY_W-1:0] w_left_key;
            logic                             w_left_move;
            logic signed [dep_pkg::KEY_W-1:0] w_right_key;

            if (i == 0) begin : g_first
                assign w_left_key  = w_key[c][i];
                assign w_left_move = 1'b0;
            end else begin : g_inner
                assign w_left_key  = w_key[c][i-1];
                assign w_left_move = w_move[c][i-1];
            end

            if (i == CAPACITY - 1) begin : g_last
                assign w_right_key = w_key[c][i];
            end else begin : g_body
                assign w_right_key = w_key[c][i+1];
            end

            dep_cell #(
                .IDX     (i),
                .DESCEND (c == 1),
                .COUNT_W (CW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl[c]),
                .i_count     (r_count),
                .i_left_key  (w_left_key),
                .i_left_move (w_left_move),
                .i_right_key (w_right_key),
                .o_key       (w_key[c][i]),
                .o_next_key  (w_next[c][i]),
                .o_move      (w_move[c][i])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_max       <= (n_count == '0) ? '0 : w_next[1][0];
            r_min       <= (n_count == '0) ? '0 : w_next[0][0];
            r_out_count <= n_count;
            r_empty     <= n_count == '0;
            r_dropped   <= w_dropped;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.max_key        = r_max;
    assign o_rsp.min_key        = r_min;
    assign o_rsp.entry_count    = r_out_count;
    assign o_rsp.is_empty       = r_empty;
    assign o_rsp.insert_dropped = r_dropped;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_empty |-> r_max >= r_min)
        else $error("Reported maximum is below the reported minimum.");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_empty |-> r_max == '0 && r_min == '0 && r_out_count == '0)
        else $error("Empty response carries keys or a count.");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_dropped |-> r_out_count == CW'(CAPACITY))
        else $error("Insert dropped while the queue was not full.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> r_count == $past(r_count))
        else $error("Entry count changed without an accepted transaction.");
`endif

endmodule

`default_nettype wire
